>>> hw/rtl/gse_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and event tables for the gillespie event step
package gse_pkg;

  localparam int RATE_W    = 48;
  localparam int WIDE_W    = 62;
  localparam int TOT_W     = 52;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 128;
  localparam int NUM_W     = 72;
  localparam int DEN_W     = 52;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 20;
  localparam int CODE_W    = 4;
  localparam int OUT_CNT_W = 14;
  localparam int NUM_RATES = 11;
  localparam int SLOT_W    = 4;

  localparam logic [CODE_W-1:0] NO_EVENT   = 4'd11;
  localparam logic [CODE_W-1:0] LAST_EVENT = 4'd10;
  localparam logic [SLOT_W-1:0] LAST_SCAN  = 4'd9;

  // compartment indexes
  localparam logic [2:0] CI_S    = 3'd0;
  localparam logic [2:0] CI_I1   = 3'd1;
  localparam logic [2:0] CI_R    = 3'd2;
  localparam logic [2:0] CI_P    = 3'd3;
  localparam logic [2:0] CI_IR   = 3'd4;
  localparam logic [2:0] CI_NONE = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_CONTACT  = 3'd0;
  localparam logic [2:0] REG_RECOVERY = 3'd1;
  localparam logic [2:0] REG_WANING   = 3'd2;
  localparam logic [2:0] REG_KAPPA    = 3'd3;
  localparam logic [2:0] REG_BIRTH    = 3'd4;
  localparam logic [2:0] REG_DEATH    = 3'd5;
  localparam logic [2:0] REG_CAP      = 3'd6;
  localparam logic [2:0] REG_TLIMIT   = 3'd7;

  // sequencer steps
  typedef enum logic [4:0] {
    OP_KIR, OP_BS, OP_X0, OP_R0, OP_BP, OP_KBP, OP_X1, OP_R1,
    OP_G1, OP_GR, OP_R3, OP_WANE, OP_BIRTH,
    OP_D0, OP_D1, OP_D2, OP_D3, OP_D4, OP_THR, OP_TDIV
  } op_t;

  typedef struct packed {
    logic            start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic [2:0] ev_dec(input logic [CODE_W-1:0] code);
    logic [2:0] r;
    case (code)
      4'd0:    r = CI_S;
      4'd1:    r = CI_P;
      4'd2:    r = CI_I1;
      4'd3:    r = CI_IR;
      4'd4:    r = CI_R;
      4'd6:    r = CI_R;
      4'd7:    r = CI_P;
      4'd8:    r = CI_S;
      4'd9:    r = CI_IR;
      4'd10:   r = CI_I1;
      default: r = CI_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ev_inc(input logic [CODE_W-1:0] code);
    logic [2:0] r;
    case (code)
      4'd0:    r = CI_I1;
      4'd1:    r = CI_IR;
      4'd2:    r = CI_R;
      4'd3:    r = CI_R;
      4'd4:    r = CI_P;
      4'd5:    r = CI_S;
      default: r = CI_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] rate_slot(input op_t op);
    logic [SLOT_W-1:0] r;
    case (op)
      OP_R0:    r = 4'd0;
      OP_R1:    r = 4'd1;
      OP_G1:    r = 4'd2;
      OP_R3:    r = 4'd3;
      OP_WANE:  r = 4'd4;
      OP_BIRTH: r = 4'd5;
      OP_D0:    r = 4'd6;
      OP_D1:    r = 4'd7;
      OP_D2:    r = 4'd8;
      OP_D3:    r = 4'd9;
      OP_D4:    r = 4'd10;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:RATE_W]) ? {RATE_W{1'b1}} : v[RATE_W-1:0];
  endfunction

  function automatic logic [WIDE_W-1:0] sat_wide(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:WIDE_W]) ? {WIDE_W{1'b1}} : v[WIDE_W-1:0];
  endfunction

endpackage

>>> hw/rtl/gse_mul.sv
`timescale 1ns / 1ps
// shared 64x64 multiplier, one 32x32 partial product per cycle
module gse_mul import gse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_W-1:0]  ar;
  logic [MUL_W-1:0]  br;
  logic [MUL_W-1:0]  pp;
  logic [1:0]        sh;
  logic [2:0]        cnt;
  logic              busy;
  logic [PROD_W-1:0] acc;
  logic [31:0]       a_sel;
  logic [31:0]       b_sel;
  logic [PROD_W-1:0] pp_shift;

  assign a_sel    = cnt[1] ? ar[63:32] : ar[31:0];
  assign b_sel    = cnt[0] ? br[63:32] : br[31:0];
  assign pp_shift = PROD_W'(pp) << (7'd32 * 7'(sh));
  assign prod     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ar   <= req.a;
        br   <= req.b;
        acc  <= '0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd0) begin
          acc <= acc + pp_shift;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          pp  <= MUL_W'(a_sel * b_sel);
          sh  <= 2'(cnt[1]) + 2'(cnt[0]);
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/gse_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module gse_div import gse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nr;
  logic [DEN_W-1:0] dr;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, nr[NUM_W-1]};
  assign fits  = trial >= {1'b0, dr};
  assign quo   = nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        nr   <= req.num;
        dr   <= req.den;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        // quotient bits shift in behind the numerator
        rem <= fits ? DEN_W'(trial - {1'b0, dr}) : trial[DEN_W-1:0];
        nr  <= {nr[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/gillespie_sirs_event_step.sv
`timescale 1ns / 1ps
// top level: gillespie direct-method event step for a five-compartment model
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | cmd, draws, five initial counts
//   out     | output    | out_valid/out_stall | event code, counts, time, flags
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// a restart, or a step once the run is done, goes from idle straight to the emit step
// an event step runs up to 16 products on the four-pass shared multiplier and
// up to 4 divisions on the bit-serial divider, plus an event selection scan
// over the rate slots and a finish step
// in_stall is high from acceptance until the result enters the output register
// reset loads default registers and clears counts, time, event index and done
module gillespie_sirs_event_step import gse_pkg::*; #(
  parameter int POP_BITS     = 14,
  parameter int EVENT_CAP    = 1000001,
  parameter int SAMPLE_EVERY = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [31:0]          uniform_draw,
  input  logic [20:0]          exp_draw,
  input  logic [13:0]          init_susceptible,
  input  logic [13:0]          init_first_infected,
  input  logic [13:0]          init_recovered,
  input  logic [13:0]          init_partial,
  input  logic [13:0]          init_reinfected,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    event_code,
  output logic [13:0]          susceptible,
  output logic [13:0]          first_infected,
  output logic [13:0]          recovered,
  output logic [13:0]          partial,
  output logic [13:0]          reinfected,
  output logic [TIME_W-1:0]    elapsed,
  output logic                 sample_point,
  output logic                 run_done,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int FORCE_W = POP_BITS + 17;
  localparam int SUM_W   = POP_BITS + 3;
  localparam int CMP_W   = (SUM_W > 14) ? SUM_W : 14;
  localparam int SAMP_W  = (SAMPLE_EVERY > 1) ? $clog2(SAMPLE_EVERY) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ISSUE = 7'b0000010,
    ST_MULW  = 7'b0000100,
    ST_DIVW  = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  op_t    op;

  // configuration
  logic [9:0]  beta;
  logic [7:0]  gam;
  logic [7:0]  rho;
  logic [15:0] kap;
  logic [15:0] bcoef;
  logic [15:0] dcoef;
  logic [13:0] cap;
  logic [31:0] tlim;

  // run state
  logic [POP_BITS-1:0] cnt_s, cnt_i1, cnt_r, cnt_p, cnt_ir;
  logic [TIME_W-1:0]   sim_time;
  logic [IDX_W-1:0]    event_index;
  logic [SAMP_W-1:0]   samp_cnt;
  logic                done_flag;

  // working registers
  logic [31:0]         ran;
  logic [20:0]         expd;
  logic [FORCE_W-1:0]  force_v;
  logic [WIDE_W-1:0]   tmp;
  logic [WIDE_W-1:0]   wide;
  logic [RATE_W-1:0]   rate [NUM_RATES];
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    cum;
  logic [SLOT_W-1:0]   k;
  logic [CODE_W-1:0]   code;
  logic                samp;

  mul_req_t            mreq;
  div_req_t            dreq;
  logic                mul_done;
  logic                div_done;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    quo;

  logic                op_div;
  logic                skip;
  logic [SUM_W-1:0]    sum;
  logic                birth_on;
  logic [13:0]         nd;
  logic [TOT_W-1:0]    cum_next;
  logic [RATE_W-1:0]   wb_rate;
  logic [TIME_W:0]     time_sum;
  logic [TIME_W-1:0]   time_sat;
  logic [2:0]          dec_i, inc_i;
  logic                in_xfer, out_xfer;
  op_t                 op_next;

  gse_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .prod(prod));
  gse_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .quo(quo));

  function automatic logic [POP_BITS-1:0] upd(input logic [POP_BITS-1:0] c,
                                              input logic [2:0] idx,
                                              input logic [2:0] dec,
                                              input logic [2:0] inc);
    logic [POP_BITS-1:0] r;
    r = c;
    if (dec == idx && c != '0) r = c - POP_BITS'(1);
    else if (inc == idx && c != '1) r = c + POP_BITS'(1);
    return r;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  assign sum      = SUM_W'(cnt_s) + SUM_W'(cnt_i1) + SUM_W'(cnt_r)
                  + SUM_W'(cnt_p) + SUM_W'(cnt_ir);
  assign birth_on = CMP_W'(sum) < CMP_W'(cap);
  assign nd       = (cap == '0) ? 14'd1 : cap;
  assign cum_next = cum + TOT_W'(rate[k]);
  assign time_sum = {1'b0, sim_time} + {1'b0, quo[TIME_W-1:0]};
  assign time_sat = ((|quo[NUM_W-1:TIME_W]) || time_sum[TIME_W]) ? '1
                                                                  : time_sum[TIME_W-1:0];
  assign dec_i    = ev_dec(code);
  assign inc_i    = ev_inc(code);
  assign op_next  = op_t'(5'(op) + 5'd1);

  // operand selection for the current step
  always_comb begin
    mreq   = '0;
    dreq   = '0;
    op_div = 1'b0;
    skip   = 1'b0;
    case (op)
      OP_KIR:   begin mreq.a = MUL_W'(kap);   mreq.b = MUL_W'(cnt_ir); end
      OP_BS:    begin mreq.a = MUL_W'(beta);  mreq.b = MUL_W'(cnt_s); end
      OP_X0:    begin mreq.a = MUL_W'(tmp);   mreq.b = MUL_W'(force_v); end
      OP_R0: begin
        op_div   = 1'b1;
        dreq.num = NUM_W'({wide, 8'b0});
        dreq.den = DEN_W'(nd);
      end
      OP_BP:    begin mreq.a = MUL_W'(beta);  mreq.b = MUL_W'(cnt_p); end
      OP_KBP:   begin mreq.a = MUL_W'(kap);   mreq.b = MUL_W'(tmp); end
      OP_X1:    begin mreq.a = MUL_W'(tmp);   mreq.b = MUL_W'(force_v); end
      OP_R1: begin
        op_div   = 1'b1;
        dreq.num = NUM_W'(wide);
        dreq.den = DEN_W'(nd);
      end
      OP_G1:    begin mreq.a = MUL_W'(gam);   mreq.b = MUL_W'(cnt_i1); end
      OP_GR:    begin mreq.a = MUL_W'(gam);   mreq.b = MUL_W'(cnt_ir); end
      OP_R3: begin
        op_div   = 1'b1;
        skip     = (tmp == '0) || (kap == '0);
        dreq.num = NUM_W'({tmp, 24'b0});
        dreq.den = DEN_W'(kap);
      end
      OP_WANE:  begin mreq.a = MUL_W'(rho);   mreq.b = MUL_W'(cnt_r); end
      OP_BIRTH: begin
        skip   = !birth_on;
        mreq.a = MUL_W'(bcoef);
        mreq.b = MUL_W'(sum);
      end
      OP_D0:    begin mreq.a = MUL_W'(dcoef); mreq.b = MUL_W'(cnt_r); end
      OP_D1:    begin mreq.a = MUL_W'(dcoef); mreq.b = MUL_W'(cnt_p); end
      OP_D2:    begin mreq.a = MUL_W'(dcoef); mreq.b = MUL_W'(cnt_s); end
      OP_D3:    begin mreq.a = MUL_W'(dcoef); mreq.b = MUL_W'(cnt_ir); end
      OP_D4:    begin mreq.a = MUL_W'(dcoef); mreq.b = MUL_W'(cnt_i1); end
      OP_THR: begin
        skip   = (total == '0);
        mreq.a = MUL_W'(ran);
        mreq.b = MUL_W'(total);
      end
      OP_TDIV: begin
        op_div   = 1'b1;
        dreq.num = NUM_W'({expd, 32'b0});
        dreq.den = total;
      end
      default: begin
        op_div = 1'b0;
      end
    endcase
    mreq.start = (state == ST_ISSUE) && !op_div && !skip;
    dreq.start = (state == ST_ISSUE) && op_div && !skip;
  end

  // rate value written back by the finishing unit
  always_comb begin
    case (op)
      OP_G1, OP_WANE: wb_rate = clamp_rate({prod[PROD_W-17:0], 16'b0});
      OP_R0, OP_R1, OP_R3: wb_rate = clamp_rate(PROD_W'(quo));
      default: wb_rate = clamp_rate(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_KIR;
      beta        <= 10'd135;
      gam         <= 8'd13;
      rho         <= 8'd30;
      kap         <= 16'd256;
      bcoef       <= 16'd1311;
      dcoef       <= 16'd1311;
      cap         <= 14'd10000;
      tlim        <= 32'd429496730;
      cnt_s       <= '0;
      cnt_i1      <= '0;
      cnt_r       <= '0;
      cnt_p       <= '0;
      cnt_ir      <= '0;
      sim_time    <= '0;
      event_index <= '0;
      samp_cnt    <= '0;
      done_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CONTACT:  beta  <= cfg_data[9:0];
          REG_RECOVERY: gam   <= cfg_data[7:0];
          REG_WANING:   rho   <= cfg_data[7:0];
          REG_KAPPA:    kap   <= cfg_data[15:0];
          REG_BIRTH:    bcoef <= cfg_data[15:0];
          REG_DEATH:    dcoef <= cfg_data[15:0];
          REG_CAP:      cap   <= cfg_data[13:0];
          REG_TLIMIT:   tlim  <= cfg_data;
          default:      tlim  <= tlim;
        endcase
      end

      // the emit step reloads the output register itself
      if (out_xfer && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            ran   <= uniform_draw;
            expd  <= exp_draw;
            code  <= NO_EVENT;
            samp  <= 1'b0;
            total <= '0;
            op    <= OP_KIR;
            if (cmd) begin
              cnt_s       <= POP_BITS'(init_susceptible);
              cnt_i1      <= POP_BITS'(init_first_infected);
              cnt_r       <= POP_BITS'(init_recovered);
              cnt_p       <= POP_BITS'(init_partial);
              cnt_ir      <= POP_BITS'(init_reinfected);
              sim_time    <= '0;
              event_index <= '0;
              samp_cnt    <= '0;
              done_flag   <= 1'b0;
              state       <= ST_EMIT;
            end else if (done_flag) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end

        ST_ISSUE: begin
          if (skip) begin
            case (op)
              OP_R3: begin
                // no reinfected recovery when gamma*Ir is zero, unbounded for zero kappa
                rate[3] <= (tmp == '0) ? '0 : '1;
                total   <= total + ((tmp == '0) ? '0 : TOT_W'({RATE_W{1'b1}}));
                op      <= op_next;
              end
              OP_BIRTH: begin
                rate[5] <= '0;
                op      <= op_next;
              end
              default: begin
                // zero total rate: no event and time runs out
                sim_time <= '1;
                state    <= ST_FIN;
              end
            endcase
          end else begin
            state <= op_div ? ST_DIVW : ST_MULW;
          end
        end

        ST_MULW: begin
          if (mul_done) begin
            if (op == OP_THR) begin
              wide  <= WIDE_W'(prod[PROD_W-1:32]);
              k     <= '0;
              cum   <= '0;
              state <= ST_SCAN;
              op    <= OP_TDIV;
            end else begin
              state <= ST_ISSUE;
              op    <= op_next;
              case (op)
                OP_KIR: force_v <= FORCE_W'(prod) + FORCE_W'({cnt_i1, 8'b0});
                OP_BS, OP_BP, OP_GR: tmp <= WIDE_W'(prod);
                OP_KBP: tmp <= sat_wide(prod);
                OP_X0, OP_X1: wide <= sat_wide(prod);
                default: begin
                  rate[rate_slot(op)] <= wb_rate;
                  total               <= total + TOT_W'(wb_rate);
                end
              endcase
            end
          end
        end

        ST_DIVW: begin
          if (div_done) begin
            if (op == OP_TDIV) begin
              cnt_s    <= upd(cnt_s,  CI_S,  dec_i, inc_i);
              cnt_i1   <= upd(cnt_i1, CI_I1, dec_i, inc_i);
              cnt_r    <= upd(cnt_r,  CI_R,  dec_i, inc_i);
              cnt_p    <= upd(cnt_p,  CI_P,  dec_i, inc_i);
              cnt_ir   <= upd(cnt_ir, CI_IR, dec_i, inc_i);
              sim_time <= time_sat;
              state    <= ST_FIN;
            end else begin
              rate[rate_slot(op)] <= wb_rate;
              total               <= total + TOT_W'(wb_rate);
              op                  <= op_next;
              state               <= ST_ISSUE;
            end
          end
        end

        ST_SCAN: begin
          cum <= cum_next;
          k   <= k + SLOT_W'(1);
          if (TOT_W'(wide) < cum_next) begin
            code  <= CODE_W'(k);
            state <= ST_ISSUE;
          end else if (k == LAST_SCAN) begin
            code  <= LAST_EVENT;
            state <= ST_ISSUE;
          end
        end

        ST_FIN: begin
          samp        <= (samp_cnt == '0);
          samp_cnt    <= (samp_cnt == SAMP_W'(SAMPLE_EVERY - 1)) ? '0
                                                                 : samp_cnt + SAMP_W'(1);
          event_index <= event_index + IDX_W'(1);
          if ((cnt_i1 == '0 && cnt_ir == '0) || sim_time > tlim ||
              ({1'b0, event_index} + (IDX_W + 1)'(1)) >= (IDX_W + 1)'(EVENT_CAP)) begin
            done_flag <= 1'b1;
          end
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            event_code     <= code;
            susceptible    <= OUT_CNT_W'(cnt_s);
            first_infected <= OUT_CNT_W'(cnt_i1);
            recovered      <= OUT_CNT_W'(cnt_r);
            partial        <= OUT_CNT_W'(cnt_p);
            reinfected     <= OUT_CNT_W'(cnt_ir);
            elapsed        <= sim_time;
            sample_point   <= samp;
            run_done       <= done_flag;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mreq.start && dreq.start))
    else $error("multiplier and divider started together");

  a_mul_done_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MULW)
    else $error("product finished outside the multiply wait");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW)
    else $error("quotient finished outside the divide wait");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != ST_IDLE)
    else $error("accepted transfer did not start work");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && cmd |=> !done_flag && sim_time == '0 && event_index == '0)
    else $error("restart did not clear the run state");
`endif

endmodule
